// File: design/bat_pkg.sv
// Shared types and constants for the breakpoint address table.
// Used by the controller, the datapath and the top level; no dependencies.

package bat_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 3;
    localparam int ADDR_W   = 16;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    // Breakpoint kinds
    localparam logic [KIND_W-1:0] KIND_SOFTWARE = 3'd0;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture the incoming item, restart the scan
        logic scan_read;  // read the next table entry
        logic apply;      // update the table and load the result
    } bat_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_scan;  // incoming item must search the table
        logic read_last;  // current scan read is the last entry
    } bat_stat_t;

endpackage

// File: design/bat_datapath.sv
// Datapath of the breakpoint address table: address memory, valid bits,
// scan compare and result registers. Depends on bat_pkg.

module bat_datapath #(
    parameter int ENTRIES = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bat_pkg::bat_ctrl_t            ctrl,
    output bat_pkg::bat_stat_t            stat,
    input  logic [bat_pkg::CMD_W-1:0]     cmd,
    input  logic [bat_pkg::KIND_W-1:0]    bp_kind,
    input  logic [bat_pkg::ADDR_W-1:0]    addr,
    output logic [bat_pkg::STATUS_W-1:0]  status,
    output logic                          hit
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // Item registers
    logic [bat_pkg::CMD_W-1:0]    cmd_reg;
    logic [bat_pkg::KIND_W-1:0]   kind_reg;
    logic [bat_pkg::ADDR_W-1:0]   addr_reg;

    // Scan registers
    logic [IW-1:0]                rd_idx_reg;
    logic [IW-1:0]                cmp_idx_reg;
    logic                         cmp_vld_reg;
    logic [bat_pkg::ADDR_W-1:0]   rd_data_reg;
    logic                         match_found_reg;
    logic [IW-1:0]                match_idx_reg;
    logic                         free_found_reg;
    logic [IW-1:0]                free_idx_reg;

    // Table storage
    logic [bat_pkg::ADDR_W-1:0]   mem [ENTRIES];
    logic [ENTRIES-1:0]           valid_reg;

    // Result registers
    logic [bat_pkg::STATUS_W-1:0] status_reg;
    logic                         hit_reg;

    logic                         kind_ok;
    logic                         cmp_valid;
    logic                         cmp_match;
    logic                         do_write;

    // Decide whether the incoming item needs a table search
    always_comb
    begin
        stat.need_scan = (cmd == bat_pkg::CMD_CHECK)
                      || (((cmd == bat_pkg::CMD_SET) || (cmd == bat_pkg::CMD_REMOVE))
                          && (bp_kind == bat_pkg::KIND_SOFTWARE));
        stat.read_last = (rd_idx_reg == LAST_IDX);
    end

    assign kind_ok   = (kind_reg == bat_pkg::KIND_SOFTWARE);
    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign cmp_match = cmp_valid && (rd_data_reg == addr_reg);
    assign do_write  = ctrl.apply && (cmd_reg == bat_pkg::CMD_SET) && kind_ok
                    && !match_found_reg && free_found_reg;

    // Capture the item on transfer
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= cmd;
            kind_reg <= bp_kind;
            addr_reg <= addr;
        end
    end

    // Address memory: one read per scan cycle, one write on apply
    always_ff @(posedge clk)
    begin
        if (ctrl.scan_read)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
        if (do_write)
        begin
            mem[free_idx_reg] <= addr_reg;
        end
    end

    // Advance the scan and record the first match and first free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg      <= '0;
            cmp_idx_reg     <= '0;
            cmp_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
        end
        else
        begin
            cmp_vld_reg <= ctrl.scan_read;
            if (ctrl.scan_read)
            begin
                cmp_idx_reg <= rd_idx_reg;
                if (!stat.read_last)
                begin
                    rd_idx_reg <= rd_idx_reg + IW'(1);
                end
            end
            if (ctrl.load)
            begin
                rd_idx_reg      <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else if (cmp_vld_reg)
            begin
                if (cmp_match && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= cmp_idx_reg;
                end
                if (!cmp_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
            end
        end
    end

    // Update valid bits on apply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.apply)
        begin
            unique case (cmd_reg)
                bat_pkg::CMD_CLEAR:
                begin
                    valid_reg <= '0;
                end
                bat_pkg::CMD_SET:
                begin
                    if (do_write)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                    end
                end
                bat_pkg::CMD_REMOVE:
                begin
                    if (kind_ok && match_found_reg)
                    begin
                        valid_reg[match_idx_reg] <= 1'b0;
                    end
                end
                default:
                begin
                    valid_reg <= valid_reg;
                end
            endcase
        end
    end

    // Load the result on apply
    always_ff @(posedge clk)
    begin
        if (ctrl.apply)
        begin
            hit_reg    <= 1'b0;
            status_reg <= bat_pkg::ST_OK;
            unique case (cmd_reg)
                bat_pkg::CMD_SET:
                begin
                    if (!kind_ok)
                    begin
                        status_reg <= bat_pkg::ST_UNSUPPORTED;
                    end
                    else if (!match_found_reg && !free_found_reg)
                    begin
                        status_reg <= bat_pkg::ST_FULL;
                    end
                end
                bat_pkg::CMD_REMOVE:
                begin
                    if (!kind_ok)
                    begin
                        status_reg <= bat_pkg::ST_UNSUPPORTED;
                    end
                end
                bat_pkg::CMD_CHECK:
                begin
                    hit_reg <= match_found_reg;
                end
                default:
                begin
                    hit_reg <= 1'b0;
                end
            endcase
        end
    end

    assign status = status_reg;
    assign hit    = hit_reg;

endmodule

// File: design/bat_controller.sv
// Sequencing state machine of the breakpoint address table: handshakes,
// scan control and result hand-off. Depends on bat_pkg.

module bat_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output bat_pkg::bat_ctrl_t  ctrl,
    input  bat_pkg::bat_stat_t  stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Decode commands and next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctrl           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = stat.need_scan ? S_SCAN : S_APPLY;
                end
            end
            S_SCAN:
            begin
                ctrl.scan_read = 1'b1;
                if (stat.read_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    ctrl.apply     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: design/breakpoint_address_table.sv
// Breakpoint address table top level: ties the controller to the datapath.
// Depends on bat_pkg, bat_controller and bat_datapath.
//
// Holds up to ENTRIES 16-bit breakpoint addresses with valid bits, one
// result per command. Set, remove and check search the table one entry a
// cycle through the single read port of the address memory, passing
// through the idle, scan, drain and apply states; clear all and set or
// remove with an unsupported kind skip the search and go from idle to
// apply. A result that is still waiting on out_stall holds the next item
// back until the stall ends. A finished result waits in the output
// register while the next item is taken in and searched. Valid bits
// clear at reset.

module breakpoint_address_table #(
    parameter int ENTRIES = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bat_pkg::CMD_W-1:0]     cmd,
    input  logic [bat_pkg::KIND_W-1:0]    bp_kind,
    input  logic [bat_pkg::ADDR_W-1:0]    addr,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bat_pkg::STATUS_W-1:0]  status,
    output logic                          hit
);

    bat_pkg::bat_ctrl_t ctrl;
    bat_pkg::bat_stat_t stat;

    // Sequencer
    bat_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    // Table and result datapath
    bat_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .stat    (stat),
        .cmd     (cmd),
        .bp_kind (bp_kind),
        .addr    (addr),
        .status  (status),
        .hit     (hit)
    );

endmodule

// File: design/bat_checker.sv
// Port-level checks for the breakpoint address table, bound to the top level.
// Depends on bat_pkg and breakpoint_address_table.

module bat_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [bat_pkg::STATUS_W-1:0]  status,
    input logic                          hit
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(hit))
        else $error("stalled result changed");

    // Stall input after each transfer while the item is worked on
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after transfer");

    // A new result only appears from a busy cycle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work");

    // A hit is only reported with an ok status
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> status == bat_pkg::ST_OK)
        else $error("hit with non-ok status");

endmodule

bind breakpoint_address_table bat_checker u_bat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .hit       (hit)
);
